FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and reset names.
`define FPR_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Clocked assertion on clk / rst_n.
`define FPR_ASSERT(label, prop, msg) \
    `FPR_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

FILE: hw/rtl/fpr_pkg.sv
// ---------------------------------------------------------------------------
// fpr_pkg
// Sizes, codes and types of the fragment pair reassembler.
// ---------------------------------------------------------------------------
package fpr_pkg;

    localparam int SLOTS             = 4;
    localparam int FIRST_PART_BYTES  = 32;
    localparam int SECOND_PART_BYTES = 32;
    localparam int SLOT_BYTES        = FIRST_PART_BYTES + SECOND_PART_BYTES;
    localparam int MEM_DEPTH         = SLOTS * SLOT_BYTES;

    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int BYTE_IDX_W = $clog2(SLOT_BYTES);

    // fragment numbers
    localparam logic [7:0] FRAME_FIRST  = 8'h00;
    localparam logic [7:0] FRAME_SECOND = 8'h01;

    typedef logic [SLOT_W-1:0]     slot_idx_t;
    typedef logic [BYTE_IDX_W-1:0] byte_idx_t;
    typedef logic [ADDR_W-1:0]     mem_addr_t;

    // what the slot table decided for one transfer
    typedef struct packed {
        logic      store;     // write the byte into the payload store
        logic      second;    // byte belongs to the second part
        slot_idx_t slot;      // slot that owns the byte
        logic      complete;  // final byte of the second part stored
    } fpr_decision_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } fpr_state_t;

    function automatic mem_addr_t byte_addr(slot_idx_t slot, byte_idx_t idx);
        return ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(idx);
    endfunction

endpackage

FILE: hw/rtl/fpr_payload_ram.sv
// ---------------------------------------------------------------------------
// fpr_payload_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module fpr_payload_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/fpr_slot_table.sv
// ---------------------------------------------------------------------------
// fpr_slot_table
// Slot bookkeeping: pending flags, serials, round-robin pointer, open slot.
// ---------------------------------------------------------------------------
module fpr_slot_table import fpr_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    frame,
    input  logic [63:0]   source_serial,
    input  logic [4:0]    byte_offset,
    output fpr_decision_t decision
);

    logic        pending_reg [SLOTS];
    logic        pending_next [SLOTS];
    logic [63:0] serial_reg [SLOTS];
    logic [63:0] serial_next [SLOTS];
    slot_idx_t   next_slot_reg, next_slot_next;
    slot_idx_t   cur_slot_reg, cur_slot_next;
    logic        active_reg, active_next;

    logic          hit;
    slot_idx_t     hit_idx;
    slot_idx_t     next_wrap;
    logic          cur_match;
    logic          off_zero;
    logic          first_fits;
    logic          second_fits;
    logic          second_last;
    fpr_decision_t dec;

    always_comb
    begin
        // lowest pending slot with this serial
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (pending_reg[i] && serial_reg[i] == source_serial)
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end

        next_wrap   = (next_slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : next_slot_reg + 1'b1;
        cur_match   = active_reg && (serial_reg[cur_slot_reg] == source_serial);
        off_zero    = (byte_offset == '0);
        first_fits  = (int'(byte_offset) < FIRST_PART_BYTES);
        second_fits = (int'(byte_offset) < SECOND_PART_BYTES);
        second_last = (int'(byte_offset) == SECOND_PART_BYTES - 1);

        pending_next   = pending_reg;
        serial_next    = serial_reg;
        next_slot_next = next_slot_reg;
        cur_slot_next  = cur_slot_reg;
        active_next    = active_reg;
        dec            = '0;
        dec.slot       = cur_slot_reg;

        case (frame)
            FRAME_FIRST:
            begin
                if (off_zero)
                begin
                    dec.slot = hit ? hit_idx : next_slot_reg;
                    if (dec.slot == next_slot_reg)
                    begin
                        next_slot_next = next_wrap;
                    end
                    pending_next[dec.slot] = 1'b1;
                    serial_next[dec.slot]  = source_serial;
                    cur_slot_next          = dec.slot;
                    active_next            = 1'b1;
                    dec.store              = first_fits;
                end
                else
                begin
                    dec.store = cur_match && pending_reg[cur_slot_reg] && first_fits;
                end
            end
            FRAME_SECOND:
            begin
                dec.second = 1'b1;
                if (off_zero)
                begin
                    if (hit)
                    begin
                        dec.slot              = hit_idx;
                        pending_next[hit_idx] = 1'b0;
                        cur_slot_next         = hit_idx;
                        active_next           = 1'b1;
                        dec.store             = second_fits;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    dec.store = cur_match && !pending_reg[cur_slot_reg] && second_fits;
                end
                dec.complete = dec.store && second_last;
                if (dec.complete)
                begin
                    active_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign decision = dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                pending_reg[i] <= 1'b0;
                serial_reg[i]  <= '0;
            end
            next_slot_reg <= '0;
            cur_slot_reg  <= '0;
            active_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg   <= pending_next;
            serial_reg    <= serial_next;
            next_slot_reg <= next_slot_next;
            cur_slot_reg  <= cur_slot_next;
            active_reg    <= active_next;
        end
    end

endmodule

FILE: hw/rtl/fragment_pair_reassembler_core.sv
// ---------------------------------------------------------------------------
// fragment_pair_reassembler_core
// Timing: a byte is stored at its input transfer; a completing byte starts
// emission, where READ reads each payload byte from the RAM and LOAD moves it
// into the output register, waiting while the held output byte is stalled.
// Throughput: 1 input per cycle in IDLE; clearing and emission stall the input.
// Reset: a clearing pass writes zero to all MEM_DEPTH (256) RAM entries.
// ---------------------------------------------------------------------------
module fragment_pair_reassembler_core import fpr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  frame,
    input  logic [63:0] source_serial,
    input  logic [4:0]  byte_offset,
    input  logic [7:0]  data_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [63:0] origin_serial,
    output logic        last_byte
);

    fpr_state_t    state_reg, state_next;
    mem_addr_t     clr_addr_reg;
    byte_idx_t     emit_idx_reg;
    slot_idx_t     emit_slot_reg;
    logic [63:0]   emit_serial_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic [63:0]   origin_serial_reg;
    logic          last_byte_reg;

    logic          in_xfer;
    logic          out_free;
    logic          emit_last;
    logic          load_out;
    fpr_decision_t dec;
    byte_idx_t     store_idx;

    logic          ram_we;
    mem_addr_t     ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    mem_addr_t     ram_raddr;
    logic [7:0]    ram_rdata;

    // Items are taken only in IDLE: the clearing pass and payload emission
    // both own the RAM and stall the input side.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    // Output register frees up when empty or when its byte is taken now.
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_last = (emit_idx_reg == BYTE_IDX_W'(SLOT_BYTES - 1));

    fpr_slot_table u_slot_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_xfer),
        .frame         (frame),
        .source_serial (source_serial),
        .byte_offset   (byte_offset),
        .decision      (dec)
    );

    // Byte position within the slot: second-part bytes sit after the first part.
    assign store_idx = dec.second ?
                       BYTE_IDX_W'(FIRST_PART_BYTES) + BYTE_IDX_W'(byte_offset) :
                       BYTE_IDX_W'(byte_offset);

    // Write port: clearing pass after reset, else the accepted byte.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = in_xfer && dec.store;
            ram_waddr = byte_addr(dec.slot, store_idx);
            ram_wdata = data_byte;
        end
    end

    // Read port walks the completed slot in byte order.
    assign ram_re    = (state_reg == ST_READ);
    assign ram_raddr = byte_addr(emit_slot_reg, emit_idx_reg);

    fpr_payload_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (8)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Sequencer: CLEAR -> IDLE; on a completing transfer READ/LOAD per byte.
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer && dec.complete)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // RAM data holds until the next read, so just wait for space
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = emit_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (in_xfer && dec.complete)
            begin
                emit_idx_reg <= '0;
            end
            else if (load_out)
            begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers. The serial is latched at completion apart from the
    // output register, which may still hold the previous payload's last byte.
    always_ff @(posedge clk)
    begin
        if (in_xfer && dec.complete)
        begin
            emit_slot_reg   <= dec.slot;
            emit_serial_reg <= source_serial;
        end
        if (load_out)
        begin
            out_byte_reg      <= ram_rdata;
            origin_serial_reg <= emit_serial_reg;
            last_byte_reg     <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign origin_serial = origin_serial_reg;
    assign last_byte     = last_byte_reg;

endmodule

FILE: hw/rtl/fpr_checker.sv
// ---------------------------------------------------------------------------
// fpr_checker
// Port-level checks on the reassembler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  frame,
    input logic [63:0] source_serial,
    input logic [4:0]  byte_offset,
    input logic [7:0]  data_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic [63:0] origin_serial,
    input logic        last_byte
);

    // held output transfer keeps its payload
    `FPR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte), "stalled output changed")

    // no input is taken while a payload is partly delivered
    `FPR_ASSERT(a_no_input_mid_payload, out_valid && !last_byte |-> in_stall, "input open during payload emission")

    // one payload carries one serial throughout
    `FPR_ASSERT(a_serial_steady, out_valid && !out_stall && !last_byte |=> $stable(origin_serial), "origin serial changed within a payload")

endmodule

bind fragment_pair_reassembler_core fpr_checker u_fpr_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - fragment_pair_reassembler_core
// A short table of directed fragments is followed by random fragment traffic.
// Every input transfer goes through a slot-table predictor. The reassembled
// bytes coming out of the core are compared in order against that prediction.
// ---------------------------------------------------------------------------
module testbench;
    import fpr_pkg::*;

    localparam int RANDOM_ITEMS  = 90;
    localparam int POOL          = 8;
    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 2 * SLOT_BYTES + 8;
    localparam int DIRECTED_ROWS = 25;

    localparam logic [63:0] SER_ZERO = 64'h0;
    localparam logic [63:0] SER_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SER_A    = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0] SER_B    = 64'hFEDC_BA98_7654_3210;
    localparam logic [63:0] SER_C    = 64'h8000_0000_0000_0001;

    // How a directed row is checked: by the predictor, as "no output", or as
    // a payload that is zero except for its four corner bytes.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_CORNERS
    } chk_mode_t;

    typedef struct packed {
        logic [7:0]  frame;
        logic [63:0] serial;
        logic [4:0]  offset;
        logic [7:0]  data;
        chk_mode_t   mode;
        logic [31:0] corners;   // bytes 0, FIRST-1, FIRST, last
    } dir_row_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [63:0] serial;
        logic        last;
    } payload_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  frame = 8'h00;
    logic [63:0] source_serial = 64'h0;
    logic [4:0]  byte_offset = 5'd0;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic [63:0] origin_serial;
    logic        last_byte;

    // predictor state
    bit          open_flag [SLOTS];
    logic [63:0] owner_serial [SLOTS];
    logic [7:0]  store_bytes [SLOTS * SLOT_BYTES];
    int          rr_ptr;
    int          fill_slot;
    bit          fill_live;

    payload_byte_t reassembled_q [$];
    payload_byte_t want;
    dir_row_t      script [DIRECTED_ROWS];
    logic [63:0]   serial_pool [POOL];

    int          errors = 0;
    int          work_items = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;
    logic [15:0] stall_mask = 16'h0;
    logic [5:0]  stall_phase = 6'd0;

    fragment_pair_reassembler_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .frame         (frame),
        .source_serial (source_serial),
        .byte_offset   (byte_offset),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .origin_serial (origin_serial),
        .last_byte     (last_byte)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Slot-table predictor: updates the state for one accepted byte and, on
    // completion of a second part, queues the whole slot payload.
    function automatic void reassemble_byte(logic [7:0] f, logic [63:0] s, logic [4:0] o,
                                            logic [7:0] d, bit emit);
        int            hit;
        int            pos;
        int            base;
        int            i;
        payload_byte_t rec;
        hit = -1;
        if (f != FRAME_FIRST && f != FRAME_SECOND)
            return;
        if (o == 5'd0)
        begin
            for (i = SLOTS - 1; i >= 0; i--)
                if (open_flag[i] && owner_serial[i] == s)
                    hit = i;
        end
        if (f == FRAME_FIRST)
        begin
            if (o == 5'd0)
            begin
                pos = (hit >= 0) ? hit : rr_ptr;
                if (pos == rr_ptr)
                    rr_ptr = (rr_ptr + 1 >= SLOTS) ? 0 : rr_ptr + 1;
                open_flag[pos] = 1'b1;
                owner_serial[pos] = s;
                fill_slot = pos;
                fill_live = 1'b1;
            end
            else if (!(fill_live && open_flag[fill_slot] && owner_serial[fill_slot] == s))
                return;
            if (int'(o) < FIRST_PART_BYTES)
                store_bytes[fill_slot * SLOT_BYTES + int'(o)] = d;
            return;
        end
        if (o == 5'd0)
        begin
            // second part with no open first part: whole fragment dropped
            if (hit < 0)
            begin
                fill_live = 1'b0;
                return;
            end
            open_flag[hit] = 1'b0;
            fill_slot = hit;
            fill_live = 1'b1;
        end
        else if (!(fill_live && !open_flag[fill_slot] && owner_serial[fill_slot] == s))
            return;
        if (int'(o) >= SECOND_PART_BYTES)
            return;
        base = fill_slot * SLOT_BYTES;
        store_bytes[base + FIRST_PART_BYTES + int'(o)] = d;
        if (int'(o) != SECOND_PART_BYTES - 1)
            return;
        if (emit)
        begin
            for (i = 0; i < SLOT_BYTES; i++)
            begin
                rec.data = store_bytes[base + i];
                rec.serial = owner_serial[fill_slot];
                rec.last = (i == SLOT_BYTES - 1);
                reassembled_q.push_back(rec);
            end
        end
        fill_live = 1'b0;
    endfunction

    // Drive one byte, wait for its transfer, predict, then pace the sender.
    task automatic push_byte(logic [7:0] f, logic [63:0] s, logic [4:0] o, logic [7:0] d,
                             chk_mode_t mode, logic [31:0] corners);
        int            k;
        int            gap;
        payload_byte_t rec;
        in_valid <= 1'b1;
        frame <= f;
        source_serial <= s;
        byte_offset <= o;
        data_byte <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        reassemble_byte(f, s, o, d, mode == CHK_MODEL);
        if (mode == CHK_CORNERS)
        begin
            for (k = 0; k < SLOT_BYTES; k++)
            begin
                rec.data = 8'h00;
                if (k == 0)
                    rec.data = corners[31:24];
                else if (k == FIRST_PART_BYTES - 1)
                    rec.data = corners[23:16];
                else if (k == FIRST_PART_BYTES)
                    rec.data = corners[15:8];
                else if (k == SLOT_BYTES - 1)
                    rec.data = corners[7:0];
                rec.serial = s;
                rec.last = (k == SLOT_BYTES - 1);
                reassembled_q.push_back(rec);
            end
        end
        if (f == FRAME_FIRST || f == FRAME_SECOND)
            work_items++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 10);
        end
        else
            burst_left--;
    endtask

    // Receiver stall pattern; bit 0 is kept clear so a stall run never spans the whole mask.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == 6'd63)
        begin
            if ($urandom_range(0, 3) == 0)
                stall_mask <= 16'h0;
            else
                stall_mask <= 16'($urandom) & 16'hFFFE;
        end
        out_stall <= stall_mask[stall_phase[3:0]];
    end

    // Output check against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (reassembled_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output transfer: expected none, got byte %h serial %h",
                         $time, out_byte, origin_serial);
            end
            else
            begin
                want = reassembled_q.pop_front();
                if (out_byte !== want.data)
                begin
                    errors++;
                    $display("%0t: out_byte expected %h, got %h", $time, want.data, out_byte);
                end
                if (origin_serial !== want.serial)
                begin
                    errors++;
                    $display("%0t: origin_serial expected %h, got %h",
                             $time, want.serial, origin_serial);
                end
                if (last_byte !== want.last)
                begin
                    errors++;
                    $display("%0t: last_byte expected %b, got %b", $time, want.last, last_byte);
                end
            end
        end
    end

    // Watchdog: too long with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          i;
        int          r;
        int          n_mid;
        int          pick;
        logic [7:0]  fr;
        logic [63:0] ser;

        for (i = 0; i < SLOTS; i++)
        begin
            open_flag[i] = 1'b0;
            owner_serial[i] = 64'h0;
        end
        for (i = 0; i < SLOTS * SLOT_BYTES; i++)
            store_bytes[i] = 8'h00;
        rr_ptr = 0;
        fill_slot = 0;
        fill_live = 1'b0;

        serial_pool[0] = SER_ZERO;
        serial_pool[1] = SER_ONES;
        serial_pool[2] = SER_A;
        serial_pool[3] = SER_B;
        for (i = 4; i < POOL; i++)
            serial_pool[i] = {$urandom, $urandom};

        script = '{
            // after reset: second part with nothing open, then its tail
            '{FRAME_SECOND, SER_A,    5'd0,  8'h3C, CHK_NONE,    32'h0},
            '{FRAME_SECOND, SER_A,    5'd31, 8'hC3, CHK_NONE,    32'h0},
            // other frame numbers are ignored
            '{8'hFF,        SER_A,    5'd0,  8'h77, CHK_NONE,    32'h0},
            '{8'h02,        SER_ZERO, 5'd0,  8'h01, CHK_NONE,    32'h0},
            // continuation with no fragment open
            '{FRAME_FIRST,  SER_A,    5'd5,  8'hE1, CHK_NONE,    32'h0},
            // slot 0 with serial zero; only the four corner bytes get written
            '{FRAME_FIRST,  SER_ZERO, 5'd0,  8'hA5, CHK_NONE,    32'h0},
            '{FRAME_FIRST,  SER_ZERO, 5'd31, 8'hFF, CHK_NONE,    32'h0},
            '{FRAME_FIRST,  SER_A,    5'd7,  8'h99, CHK_NONE,    32'h0},
            '{FRAME_SECOND, SER_ZERO, 5'd5,  8'h44, CHK_NONE,    32'h0},
            '{FRAME_SECOND, SER_ZERO, 5'd0,  8'h80, CHK_NONE,    32'h0},
            '{FRAME_FIRST,  SER_ZERO, 5'd9,  8'h55, CHK_NONE,    32'h0},
            '{FRAME_SECOND, SER_ZERO, 5'd31, 8'h5A, CHK_CORNERS, 32'hA5FF_805A},
            // tail after completion is ignored
            '{FRAME_SECOND, SER_ZERO, 5'd5,  8'h66, CHK_NONE,    32'h0},
            // reuse of a pending slot, interleaving, serial mismatch, wrap
            '{FRAME_FIRST,  SER_ONES, 5'd0,  8'h11, CHK_MODEL,   32'h0},
            '{FRAME_FIRST,  SER_ONES, 5'd3,  8'h22, CHK_MODEL,   32'h0},
            '{FRAME_FIRST,  SER_ONES, 5'd0,  8'h33, CHK_MODEL,   32'h0},
            '{FRAME_FIRST,  SER_A,    5'd0,  8'h44, CHK_MODEL,   32'h0},
            '{FRAME_FIRST,  SER_A,    5'd1,  8'h55, CHK_MODEL,   32'h0},
            '{FRAME_SECOND, SER_ONES, 5'd0,  8'h66, CHK_MODEL,   32'h0},
            '{FRAME_SECOND, SER_A,    5'd1,  8'h77, CHK_MODEL,   32'h0},
            '{FRAME_SECOND, SER_ONES, 5'd31, 8'h88, CHK_MODEL,   32'h0},
            '{FRAME_FIRST,  SER_B,    5'd0,  8'h99, CHK_MODEL,   32'h0},
            '{FRAME_FIRST,  SER_C,    5'd0,  8'hAA, CHK_MODEL,   32'h0},
            '{FRAME_SECOND, SER_A,    5'd0,  8'hBB, CHK_MODEL,   32'h0},
            '{FRAME_SECOND, SER_A,    5'd31, 8'hCC, CHK_MODEL,   32'h0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            push_byte(script[i].frame, script[i].serial, script[i].offset, script[i].data,
                      script[i].mode, script[i].corners);

        work_items = 0;
        while (work_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                // well-formed fragment: offset 0, a few middle bytes, usually the tail
                fr = ($urandom_range(0, 1) == 0) ? FRAME_FIRST : FRAME_SECOND;
                ser = serial_pool[$urandom_range(0, POOL - 1)];
                pick = $urandom_range(0, SLOTS - 1);
                if (fr == FRAME_SECOND && open_flag[pick] && $urandom_range(0, 3) != 0)
                    ser = owner_serial[pick];
                push_byte(fr, ser, 5'd0, 8'($urandom), CHK_MODEL, 32'h0);
                n_mid = $urandom_range(0, 4);
                repeat (n_mid)
                    push_byte(fr, ser, 5'($urandom_range(1, 30)), 8'($urandom),
                              CHK_MODEL, 32'h0);
                if ($urandom_range(0, 7) != 0)
                    push_byte(fr, ser, 5'd31, 8'($urandom), CHK_MODEL, 32'h0);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: fr = FRAME_FIRST;
                    1: fr = FRAME_SECOND;
                    default: fr = 8'($urandom);
                endcase
                ser = ($urandom_range(0, 1) == 0) ? serial_pool[$urandom_range(0, POOL - 1)]
                                                  : {$urandom, $urandom};
                push_byte(fr, ser, 5'($urandom), 8'($urandom), CHK_MODEL, 32'h0);
            end
        end

        in_valid <= 1'b0;
        while (reassembled_q.size() != 0)
            @(posedge clk);
        // catch any stray bytes after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
